/* hw/rtl/polynomial_mutation_element_defines.svh */
// ----------------------------------------------------------------------------
// polynomial_mutation_element_defines
// assertion macros shared by the polynomial mutation datapath
// ----------------------------------------------------------------------------
`ifndef POLYNOMIAL_MUTATION_ELEMENT_DEFINES_SVH
`define POLYNOMIAL_MUTATION_ELEMENT_DEFINES_SVH

`ifndef ASSERT_OFF
`define PMUT_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("pmut check failed: %m");
`define PMUT_ASSERT_VLD(label, vld, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (vld) |-> (prop)) \
        else $error("pmut check failed: %m");
`else
`define PMUT_ASSERT(label, prop)
`define PMUT_ASSERT_VLD(label, vld, prop)
`endif

`endif

/* hw/rtl/pmut_pkg.sv */
// ----------------------------------------------------------------------------
// pmut_pkg
// types, constants and elaboration-time helpers of the polynomial mutation block
// ----------------------------------------------------------------------------
package pmut_pkg;

    localparam int unsigned VAL_W   = 32;
    localparam int unsigned Q16_W   = 17;
    localparam int unsigned RAND_W  = 16;
    localparam int unsigned DIST_W  = 16;
    localparam int unsigned PROB_W  = 17;
    localparam int unsigned EXPO_W  = 17;
    localparam int unsigned LOG_W   = 21;
    localparam int unsigned EXPM_W  = 30;
    localparam int unsigned STEPS   = 16;
    localparam int unsigned Z_W     = 31;
    localparam int unsigned IDX_W   = 2;
    localparam int unsigned CFG_W   = 17;

    localparam logic [Q16_W-1:0]  ONE_Q16    = 17'h10000;
    localparam logic [RAND_W-1:0] HALF_Q16   = 16'h8000;
    localparam logic [EXPO_W-1:0] EXPO_ONE   = 17'd256;
    localparam logic [DIST_W-1:0] DIST_RESET = 16'd5120;
    localparam logic [PROB_W-1:0] PROB_RESET = 17'd6554;

    localparam logic [IDX_W-1:0] REG_DIST_INDEX  = 2'd0;
    localparam logic [IDX_W-1:0] REG_MUTATE_PROB = 2'd1;

    typedef struct packed {
        logic signed [VAL_W-1:0] x;
        logic signed [VAL_W-1:0] lb;
        logic signed [VAL_W-1:0] ub;
        logic [VAL_W-1:0]        delta;
        logic [RAND_W-1:0]       rs;
        logic                    up;
        logic                    mut;
        logic                    empty;
        logic                    zero;
    } side_t;

    // j-th root of the chain 2^(2^-(j+1)) in Q1.30, truncating integer square roots
    function automatic logic [Z_W-1:0] pmut_root(input int unsigned j);
        logic [63:0] r;
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] b;
        int unsigned s;
        int unsigned n;
        r = 64'h8000_0000;
        for (s = 0; s <= j; s++)
        begin
            v   = r << 30;
            res = '0;
            b   = 64'd1 << 62;
            for (n = 0; n < 32; n++)
            begin
                if (v >= res + b)
                begin
                    v   = v - (res + b);
                    res = (res >> 1) + b;
                end
                else
                begin
                    res = res >> 1;
                end
                b = b >> 2;
            end
            r = res;
        end
        return r[Z_W-1:0];
    endfunction

endpackage

/* hw/rtl/polynomial_mutation_element.sv */
// throughput: one request per cycle unless a result is stalled at the output, set by
// the fully pipelined log2/exp2 and divider chains
// a stalled result holds the whole pipeline in place; nothing is dropped or repeated
// reset: asynchronous, active low; clears all valid bits and loads
// dist_index = 5120 (eta 20.0) and mutate_prob = 6554
// ----------------------------------------------------------------------------
// polynomial_mutation_element
// per-coordinate polynomial mutation, Q16.16, deep pipeline
// ----------------------------------------------------------------------------
`include "polynomial_mutation_element_defines.svh"

module polynomial_mutation_element
    import pmut_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [IDX_W-1:0]        cfg_index,
    input  logic [CFG_W-1:0]        cfg_data,
    input  logic                    item_valid,
    output logic                    item_ready,
    input  logic signed [VAL_W-1:0] gene_value,
    input  logic signed [VAL_W-1:0] lower_bound,
    input  logic signed [VAL_W-1:0] upper_bound,
    input  logic [RAND_W-1:0]       rand_decide,
    input  logic [RAND_W-1:0]       rand_shape,
    output logic                    result_valid,
    input  logic                    result_ready,
    output logic signed [VAL_W-1:0] new_value,
    output logic                    was_mutated
);

    localparam int unsigned SUM_W = VAL_W + 3;
    localparam int unsigned MAG_W = VAL_W + 1;

    logic [DIST_W-1:0] dist_index_reg;
    logic [PROB_W-1:0] mutate_prob_reg;
    logic [EXPO_W-1:0] expo;
    logic              en;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dist_index_reg  <= DIST_RESET;
            mutate_prob_reg <= PROB_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_DIST_INDEX:  dist_index_reg  <= cfg_data[DIST_W-1:0];
                REG_MUTATE_PROB: mutate_prob_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    assign expo       = EXPO_W'(dist_index_reg) + EXPO_ONE;
    assign en         = !result_valid || result_ready;
    assign item_ready = en;

    // stage a: capture request
    logic  vld_a_reg;
    side_t side_a_reg;

    // stage b: clamp, interval width
    logic                    vld_b_reg;
    side_t                   side_b_reg;
    side_t                   side_b_next;
    logic signed [VAL_W-1:0] xc_b_reg;
    logic signed [VAL_W-1:0] xc_next;

    always_comb
    begin
        priority if (side_a_reg.x < side_a_reg.lb)
        begin
            xc_next = side_a_reg.lb;
        end
        else if (side_a_reg.x > side_a_reg.ub)
        begin
            xc_next = side_a_reg.ub;
        end
        else
        begin
            xc_next = side_a_reg.x;
        end
    end

    always_comb
    begin
        side_b_next       = side_a_reg;
        side_b_next.delta = VAL_W'(side_a_reg.ub - side_a_reg.lb);
        side_b_next.empty = side_a_reg.ub <= side_a_reg.lb;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_a_reg <= item_valid;
            vld_b_reg <= vld_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_a_reg.x     <= gene_value;
            side_a_reg.lb    <= lower_bound;
            side_a_reg.ub    <= upper_bound;
            side_a_reg.delta <= '0;
            side_a_reg.rs    <= rand_shape;
            side_a_reg.up    <= rand_shape > HALF_Q16;
            side_a_reg.mut   <= PROB_W'(rand_decide) < mutate_prob_reg;
            side_a_reg.empty <= 1'b0;
            side_a_reg.zero  <= 1'b0;

            side_b_reg       <= side_b_next;
            xc_b_reg         <= xc_next;
        end
    end

    // ratio of the distance to the bound on the side of the step
    logic [VAL_W-1:0] dist_b;
    logic             div1_vld;
    logic [Q16_W-1:0] t_q;
    side_t            div1_side;

    assign dist_b = side_b_reg.up ? VAL_W'(side_b_reg.ub - xc_b_reg)
                                  : VAL_W'(xc_b_reg - side_b_reg.lb);

    pmut_div #(
        .NUM_W (VAL_W + 16),
        .DEN_W (VAL_W),
        .Q_W   (Q16_W)
    ) u_div_ratio (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vld_b_reg),
        .num       ({dist_b, 16'b0}),
        .den       (side_b_reg.delta),
        .in_side   (side_b_reg),
        .out_valid (div1_vld),
        .quot      (t_q),
        .out_side  (div1_side)
    );

    // pow(xy, eta+1)
    side_t            log1_in_side;
    logic             log1_vld;
    logic [LOG_W-1:0] nl1;
    side_t            log1_side;

    always_comb
    begin
        log1_in_side      = div1_side;
        log1_in_side.zero = t_q == ONE_Q16;
    end

    pmut_log u_log_up (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (div1_vld),
        .v         (ONE_Q16 - t_q),
        .in_side   (log1_in_side),
        .out_valid (log1_vld),
        .nl        (nl1),
        .out_side  (log1_side)
    );

    logic [LOG_W+EXPO_W-1:0] m1_full;
    logic                    vld_m1_reg;
    logic [EXPM_W-1:0]       m1_reg;
    side_t                   side_m1_reg;

    assign m1_full = nl1 * expo;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_reg      <= m1_full[EXPM_W+7:8];
            side_m1_reg <= log1_side;
        end
    end

    logic             exp1_vld;
    logic [Q16_W-1:0] pw;
    side_t            exp1_side;

    pmut_exp u_exp_up (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vld_m1_reg),
        .m         (m1_reg),
        .in_side   (side_m1_reg),
        .out_valid (exp1_vld),
        .y         (pw),
        .out_side  (exp1_side)
    );

    // mix with the shape fraction
    logic [Q16_W-1:0]   pwz;
    logic [Q16_W-1:0]   two_rs;
    logic [Q16_W-1:0]   base_v;
    logic [Q16_W-1:0]   coef_v;
    logic [2*Q16_W-1:0] vprod;
    logic               vld_v_reg;
    logic [Q16_W-1:0]   val_reg;
    side_t              side_v_reg;

    assign pwz    = exp1_side.zero ? '0 : pw;
    assign two_rs = {exp1_side.rs, 1'b0};
    assign base_v = exp1_side.up ? Q16_W'({ONE_Q16, 1'b0} - {1'b0, two_rs}) : two_rs;
    assign coef_v = exp1_side.up ? Q16_W'(two_rs - ONE_Q16) : Q16_W'(ONE_Q16 - two_rs);
    assign vprod  = coef_v * pwz;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            val_reg    <= Q16_W'(base_v + vprod[2*Q16_W-1:16]);
            side_v_reg <= exp1_side;
        end
    end

    // pow(val, 1/(eta+1))
    side_t            log2_in_side;
    logic             log2_vld;
    logic [LOG_W-1:0] nl2;
    side_t            log2_side;

    always_comb
    begin
        log2_in_side      = side_v_reg;
        log2_in_side.zero = val_reg == '0;
    end

    pmut_log u_log_down (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vld_v_reg),
        .v         (val_reg),
        .in_side   (log2_in_side),
        .out_valid (log2_vld),
        .nl        (nl2),
        .out_side  (log2_side)
    );

    logic             div2_vld;
    logic [LOG_W-1:0] q2;
    side_t            div2_side;

    pmut_div #(
        .NUM_W (LOG_W + 8),
        .DEN_W (EXPO_W),
        .Q_W   (LOG_W)
    ) u_div_expo (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (log2_vld),
        .num       ({nl2, 8'b0}),
        .den       (expo),
        .in_side   (log2_side),
        .out_valid (div2_vld),
        .quot      (q2),
        .out_side  (div2_side)
    );

    logic             exp2_vld;
    logic [Q16_W-1:0] q;
    side_t            exp2_side;

    pmut_exp u_exp_down (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (div2_vld),
        .m         (EXPM_W'(q2)),
        .in_side   (div2_side),
        .out_valid (exp2_vld),
        .y         (q),
        .out_side  (exp2_side)
    );

    // scale by the interval, round half up
    logic [Q16_W-1:0]       mag;
    logic [Q16_W+VAL_W-1:0] gprod;
    logic [Q16_W+VAL_W-1:0] gsum;
    logic                   vld_g_reg;
    logic [MAG_W-1:0]       magd_reg;
    side_t                  side_g_reg;

    assign mag   = ONE_Q16 - (exp2_side.zero ? '0 : q);
    assign gprod = mag * exp2_side.delta;
    assign gsum  = gprod + (Q16_W + VAL_W)'(HALF_Q16);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            magd_reg   <= gsum[Q16_W+VAL_W-1:16];
            side_g_reg <= exp2_side;
        end
    end

    // apply the step
    logic                    vld_h_reg;
    logic signed [SUM_W-1:0] sum_reg;
    side_t                   side_h_reg;
    logic signed [SUM_W-1:0] xs;
    logic signed [SUM_W-1:0] ms;

    assign xs = SUM_W'(side_g_reg.x);
    assign ms = signed'(SUM_W'(magd_reg));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_reg    <= side_g_reg.up ? xs + ms : xs - ms;
            side_h_reg <= side_g_reg;
        end
    end

    // clip and select
    logic signed [SUM_W-1:0] lbs;
    logic signed [SUM_W-1:0] ubs;
    logic signed [VAL_W-1:0] res_next;
    logic                    flag_next;
    logic signed [VAL_W-1:0] new_value_reg;
    logic                    was_mutated_reg;
    logic                    result_valid_reg;

    assign lbs = SUM_W'(side_h_reg.lb);
    assign ubs = SUM_W'(side_h_reg.ub);

    always_comb
    begin
        flag_next = side_h_reg.mut;
        priority if (!side_h_reg.mut)
        begin
            res_next = side_h_reg.x;
        end
        else if (side_h_reg.empty)
        begin
            res_next = side_h_reg.lb;
        end
        else if (sum_reg < lbs)
        begin
            res_next = side_h_reg.lb;
        end
        else if (sum_reg > ubs)
        begin
            res_next = side_h_reg.ub;
        end
        else
        begin
            res_next = sum_reg[VAL_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_m1_reg       <= 1'b0;
            vld_v_reg        <= 1'b0;
            vld_g_reg        <= 1'b0;
            vld_h_reg        <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_m1_reg       <= log1_vld;
            vld_v_reg        <= exp1_vld;
            vld_g_reg        <= exp2_vld;
            vld_h_reg        <= vld_g_reg;
            result_valid_reg <= vld_h_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            new_value_reg   <= res_next;
            was_mutated_reg <= flag_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign new_value    = new_value_reg;
    assign was_mutated  = was_mutated_reg;

    `PMUT_ASSERT_VLD(a_ratio_range, div1_vld && !div1_side.empty, t_q <= ONE_Q16)
    `PMUT_ASSERT_VLD(a_pow_up_range, exp1_vld, pw <= ONE_Q16)
    `PMUT_ASSERT_VLD(a_mix_range, vld_v_reg, val_reg <= ONE_Q16)
    `PMUT_ASSERT_VLD(a_pow_down_range, exp2_vld, q <= ONE_Q16)
    `PMUT_ASSERT(a_stall_freezes_tail, !en |=> $stable(vld_h_reg) && $stable(sum_reg))

endmodule

/* hw/rtl/pmut_div.sv */
// ----------------------------------------------------------------------------
// pmut_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module pmut_div
    import pmut_pkg::*;
#(
    parameter int unsigned NUM_W = 49,
    parameter int unsigned DEN_W = 32,
    parameter int unsigned Q_W   = 17
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    input  side_t            in_side,
    output logic             out_valid,
    output logic [Q_W-1:0]   quot,
    output side_t            out_side
);

    logic [Q_W:0]       vld_reg;
    logic [DEN_W-1:0]   rem_reg  [Q_W];
    logic [Q_W-1:0]     low_reg  [Q_W];
    logic [DEN_W-1:0]   den_reg  [Q_W];
    logic [Q_W-1:0]     quo_reg  [Q_W+1];
    side_t              side_reg [Q_W+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[Q_W-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= DEN_W'(num >> Q_W);
            low_reg[0]  <= num[Q_W-1:0];
            den_reg[0]  <= den;
            quo_reg[0]  <= '0;
            side_reg[0] <= in_side;
        end
    end

    for (genvar k = 0; k < Q_W; k++)
    begin : g_step
        logic [DEN_W:0] trial;
        logic           ge;

        assign trial = {rem_reg[k], low_reg[k][Q_W-1]};
        assign ge    = trial >= {1'b0, den_reg[k]};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                quo_reg[k+1]  <= {quo_reg[k][Q_W-2:0], ge};
                side_reg[k+1] <= side_reg[k];
            end
        end

        if (k < Q_W - 1)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k+1] <= ge ? DEN_W'(trial - {1'b0, den_reg[k]}) : DEN_W'(trial);
                    low_reg[k+1] <= {low_reg[k][Q_W-2:0], 1'b0};
                    den_reg[k+1] <= den_reg[k];
                end
            end
        end
    end

    assign out_valid = vld_reg[Q_W];
    assign quot      = quo_reg[Q_W];
    assign out_side  = side_reg[Q_W];

endmodule

/* hw/rtl/pmut_log.sv */
// ----------------------------------------------------------------------------
// pmut_log
// pipelined magnitude of log2 for a Q16 value in (0,1], one squaring per stage
// ----------------------------------------------------------------------------
module pmut_log
    import pmut_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [Q16_W-1:0] v,
    input  side_t            in_side,
    output logic             out_valid,
    output logic [LOG_W-1:0] nl,
    output side_t            out_side
);

    localparam logic [4:0] P_TOP = 5'd16;
    localparam logic [4:0] Z_TOP = 5'd30;

    logic [STEPS+1:0]  vld_reg;
    logic [Z_W-1:0]    z_reg    [STEPS];
    logic [STEPS-1:0]  frac_reg [STEPS+1];
    logic [4:0]        p_reg    [STEPS+1];
    side_t             side_reg [STEPS+2];
    logic [LOG_W-1:0]  nl_reg;
    logic [4:0]        p_next;
    logic [Z_W-1:0]    z_next;

    // leading one and normalization to [1,2) in Q1.30
    always_comb
    begin
        p_next = '0;
        for (int i = 0; i < Q16_W; i++)
        begin
            if (v[i])
            begin
                p_next = 5'(i);
            end
        end
        z_next = Z_W'({{(Z_W-Q16_W){1'b0}}, v} << (Z_TOP - p_next));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[STEPS:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            z_reg[0]    <= z_next;
            p_reg[0]    <= p_next;
            frac_reg[0] <= '0;
            side_reg[0] <= in_side;
        end
    end

    for (genvar j = 0; j < STEPS; j++)
    begin : g_sq
        logic [2*Z_W-1:0] sq;
        logic [Z_W:0]     s;

        assign sq = z_reg[j] * z_reg[j];
        assign s  = sq[2*Z_W-1:Z_W-1];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                frac_reg[j+1] <= {frac_reg[j][STEPS-2:0], s[Z_W]};
                p_reg[j+1]    <= p_reg[j];
                side_reg[j+1] <= side_reg[j];
            end
        end

        if (j < STEPS - 1)
        begin : g_z
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    z_reg[j+1] <= s[Z_W] ? s[Z_W:1] : s[Z_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nl_reg <= {P_TOP - p_reg[STEPS], 16'b0} - LOG_W'(frac_reg[STEPS]);
            side_reg[STEPS+1] <= side_reg[STEPS];
        end
    end

    assign out_valid = vld_reg[STEPS+1];
    assign nl        = nl_reg;
    assign out_side  = side_reg[STEPS+1];

endmodule

/* hw/rtl/pmut_exp.sv */
// ----------------------------------------------------------------------------
// pmut_exp
// pipelined 2^(-m) in Q16 for a non-negative Q16 argument, one root per stage
// ----------------------------------------------------------------------------
module pmut_exp
    import pmut_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [EXPM_W-1:0] m,
    input  side_t             in_side,
    output logic              out_valid,
    output logic [Q16_W-1:0]  y,
    output side_t             out_side
);

    localparam int unsigned K_W   = EXPM_W - 15;
    localparam logic [K_W-1:0] K_MAX = K_W'(26);
    localparam logic [5:0] SH_BASE   = 6'd14;
    localparam logic [Z_W-1:0] ONE_Q30 = Z_W'(32'h4000_0000);

    logic [STEPS+1:0]  vld_reg;
    logic [Z_W-1:0]    prod_reg [STEPS+1];
    logic [STEPS-1:0]  h_reg    [STEPS];
    logic [K_W-1:0]    k_reg    [STEPS+1];
    side_t             side_reg [STEPS+2];
    logic [Q16_W-1:0]  y_reg;
    logic [15:0]       g_in;

    assign g_in = m[15:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[STEPS:0], in_valid};
        end
    end

    // split into whole part, rounded up, and one minus the fraction
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg[0] <= ONE_Q30;
            h_reg[0]    <= 16'(-g_in);
            k_reg[0]    <= K_W'(m[EXPM_W-1:16]) + K_W'(g_in != '0);
            side_reg[0] <= in_side;
        end
    end

    for (genvar j = 0; j < STEPS; j++)
    begin : g_mul
        localparam logic [Z_W-1:0] ROOT = pmut_root(j);
        logic [2*Z_W-1:0] mp;

        assign mp = prod_reg[j] * ROOT;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                prod_reg[j+1] <= h_reg[j][STEPS-1] ? mp[2*Z_W-2:Z_W-1] : prod_reg[j];
                k_reg[j+1]    <= k_reg[j];
                side_reg[j+1] <= side_reg[j];
            end
        end

        if (j < STEPS - 1)
        begin : g_h
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    h_reg[j+1] <= {h_reg[j][STEPS-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (k_reg[STEPS] > K_MAX)
            begin
                y_reg <= '0;
            end
            else
            begin
                y_reg <= Q16_W'(prod_reg[STEPS] >> (SH_BASE + 6'(k_reg[STEPS][4:0])));
            end
            side_reg[STEPS+1] <= side_reg[STEPS];
        end
    end

    assign out_valid = vld_reg[STEPS+1];
    assign y         = y_reg;
    assign out_side  = side_reg[STEPS+1];

endmodule

/* bench/polynomial_mutation_element_tb.sv */
// ----------------------------------------------------------------------------
// polynomial_mutation_element_tb
// drives genes with bounds and random fractions through the mutation block,
// predicts each result in fixed point and compares it field by field, over
// several settings of eta and of the mutation probability
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module polynomial_mutation_element_tb;
    import pmut_pkg::*;

    typedef struct {
        logic signed [VAL_W-1:0] value;
        logic                    mutated;
    } mut_result_t;

    class mutation_scoreboard;
        logic [DIST_W-1:0] eta_q;
        logic [PROB_W-1:0] prob;
        mut_result_t       pending_q[$];
        int                errors;

        function new();
            eta_q  = DIST_RESET;
            prob   = PROB_RESET;
            errors = 0;
        endfunction

        function longint unsigned int_sqrt(longint unsigned v);
            longint unsigned res;
            longint unsigned b;
            res = 0;
            b   = 64'd1 << 62;
            while (b > v)
                b = b >> 2;
            while (b != 0)
            begin
                if (v >= res + b)
                begin
                    v   = v - (res + b);
                    res = (res >> 1) + b;
                end
                else
                begin
                    res = res >> 1;
                end
                b = b >> 2;
            end
            return res;
        endfunction

        function longint unsigned log2_mag(longint unsigned v);
            int              p;
            int              i;
            longint unsigned z;
            longint unsigned frac;
            p    = 16;
            frac = 0;
            while (p > 0 && v[p] == 1'b0)
                p--;
            z = v << (30 - p);
            for (i = 15; i >= 0; i--)
            begin
                z = (z * z) >> 30;
                if (z >= (64'd2 << 30))
                begin
                    z    = z >> 1;
                    frac = frac | (64'd1 << i);
                end
            end
            return longint'(16 - p) * 65536 - frac;
        endfunction

        function longint unsigned exp2_of_neg(longint unsigned m);
            longint unsigned k;
            longint unsigned g;
            longint unsigned h;
            longint unsigned prod;
            longint unsigned r;
            int              i;
            k    = m >> 16;
            g    = m & 64'hFFFF;
            prod = 64'd1 << 30;
            r    = 64'd1 << 31;
            if (g == 0)
                h = 0;
            else
            begin
                h = 65536 - g;
                k = k + 1;
            end
            for (i = 15; i >= 0; i--)
            begin
                r = int_sqrt(r << 30);
                if (h[i])
                    prod = (prod * r) >> 30;
            end
            if (14 + k > 40)
                return 0;
            return (prod >> (14 + k)) & 64'hFFFF_FFFF;
        endfunction

        function longint unsigned pow_raise(longint unsigned b, longint unsigned e);
            if (b == 0)
                return 0;
            return exp2_of_neg((log2_mag(b) * e) >> 8);
        endfunction

        function longint unsigned pow_root(longint unsigned b, longint unsigned e);
            if (b == 0)
                return 0;
            return exp2_of_neg((log2_mag(b) << 8) / e);
        endfunction

        function void note_request(logic signed [VAL_W-1:0] gx, logic signed [VAL_W-1:0] glb,
                                   logic signed [VAL_W-1:0] gub, logic [RAND_W-1:0] rd,
                                   logic [RAND_W-1:0] rs);
            longint          x;
            longint          lb;
            longint          ub;
            longint          xc;
            longint          res;
            longint unsigned span;
            longint unsigned expo;
            longint unsigned t;
            longint unsigned pw;
            longint unsigned val;
            longint unsigned mag;
            longint unsigned rsl;
            mut_result_t     e;
            x   = gx;
            lb  = glb;
            ub  = gub;
            rsl = rs;
            if (rd >= prob)
            begin
                e.value   = gx;
                e.mutated = 1'b0;
            end
            else if (ub <= lb)
            begin
                e.value   = glb;
                e.mutated = 1'b1;
            end
            else
            begin
                span = ub - lb;
                expo = eta_q + 256;
                xc   = x < lb ? lb : (x > ub ? ub : x);
                if (rsl <= 32768)
                begin
                    t   = ((xc - lb) << 16) / span;
                    pw  = pow_raise(65536 - t, expo);
                    val = 2 * rsl + (((65536 - 2 * rsl) * pw) >> 16);
                end
                else
                begin
                    t   = ((ub - xc) << 16) / span;
                    pw  = pow_raise(65536 - t, expo);
                    val = (131072 - 2 * rsl) + (((2 * rsl - 65536) * pw) >> 16);
                end
                mag = 65536 - pow_root(val, expo);
                mag = (mag * span + 32768) >> 16;
                res = (rsl > 32768) ? x + longint'(mag) : x - longint'(mag);
                if (res < lb)
                    res = lb;
                if (res > ub)
                    res = ub;
                e.value   = res[31:0];
                e.mutated = 1'b1;
            end
            pending_q.push_back(e);
        endfunction

        function void check_result(logic signed [VAL_W-1:0] v, logic m);
            mut_result_t e;
            if (pending_q.size() == 0)
            begin
                $error("unexpected result new_value=%0d was_mutated=%0d", v, m);
                errors++;
                return;
            end
            e = pending_q.pop_front();
            if (v !== e.value)
            begin
                $error("new_value expected %0d actual %0d", e.value, v);
                errors++;
            end
            if (m !== e.mutated)
            begin
                $error("was_mutated expected %0d actual %0d", e.mutated, m);
                errors++;
            end
        endfunction
    endclass

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [IDX_W-1:0]        cfg_index;
    logic [CFG_W-1:0]        cfg_data;
    logic                    item_valid;
    logic                    item_ready;
    logic signed [VAL_W-1:0] gene_value;
    logic signed [VAL_W-1:0] lower_bound;
    logic signed [VAL_W-1:0] upper_bound;
    logic [RAND_W-1:0]       rand_decide;
    logic [RAND_W-1:0]       rand_shape;
    logic                    result_valid;
    logic                    result_ready;
    logic signed [VAL_W-1:0] new_value;
    logic                    was_mutated;

    mutation_scoreboard sb;
    int                 cycles;
    int                 results_seen;

    polynomial_mutation_element u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .gene_value   (gene_value),
        .lower_bound  (lower_bound),
        .upper_bound  (upper_bound),
        .rand_decide  (rand_decide),
        .rand_shape   (rand_shape),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .new_value    (new_value),
        .was_mutated  (was_mutated)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 2000000)
        begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 93)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 60);
    endfunction

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == REG_DIST_INDEX)
            sb.eta_q = data[DIST_W-1:0];
        else
            sb.prob = data;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_item(logic signed [VAL_W-1:0] x, logic signed [VAL_W-1:0] lb,
                             logic signed [VAL_W-1:0] ub, logic [RAND_W-1:0] rd,
                             logic [RAND_W-1:0] rs);
        int gap;
        item_valid  <= 1'b1;
        gene_value  <= x;
        lower_bound <= lb;
        upper_bound <= ub;
        rand_decide <= rd;
        rand_shape  <= rs;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        sb.note_request(x, lb, ub, rd, rs);
        gap = pick_gap();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_random();
        longint lb;
        longint ub;
        longint span;
        longint x;
        int     mode;
        logic [RAND_W-1:0] rd;
        logic [RAND_W-1:0] rs;
        mode = $urandom_range(0, 9);
        lb   = $signed($urandom());
        if (mode == 0)
            ub = $signed($urandom());
        else if (mode == 1)
            ub = lb;
        else
        begin
            if ($urandom_range(0, 2) == 0)
                span = {$urandom(), $urandom()} & 64'hFFFF_FFFF;
            else
                span = $urandom_range(1, 1 << 20);
            if (span == 0)
                span = 1;
            ub = lb + span;
            if (ub > 64'sd2147483647)
                ub = 64'sd2147483647;
            if (ub <= lb)
            begin
                lb = lb - span;
                if (lb < -64'sd2147483648)
                    lb = -64'sd2147483648;
                ub = 64'sd2147483647;
            end
        end
        if ($urandom_range(0, 3) != 0 && ub > lb)
            x = lb + longint'(({$urandom(), $urandom()} & 64'h7FFF_FFFF_FFFF_FFFF)
                              % (ub - lb + 1));
        else
            x = $signed($urandom());
        if ($urandom_range(0, 1) == 0 || sb.prob == 0)
            rd = RAND_W'($urandom());
        else
            rd = RAND_W'($urandom_range(0, sb.prob > 65535 ? 65535 : sb.prob - 1));
        case ($urandom_range(0, 11))
            0: rs = 16'd0;
            1: rs = HALF_Q16;
            2: rs = HALF_Q16 + 16'd1;
            3: rs = 16'hFFFF;
            default: rs = RAND_W'($urandom());
        endcase
        send_item(x[31:0], lb[31:0], ub[31:0], rd, rs);
    endtask

    task automatic drain();
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (140) @(posedge clk);
    endtask

    task automatic run_directed();
        send_item(32'sd0, -32'sd65536, 32'sd65536, 16'd0, 16'd0);
        send_item(32'sd0, -32'sd65536, 32'sd65536, 16'd0, HALF_Q16);
        send_item(32'sd0, -32'sd65536, 32'sd65536, 16'd0, HALF_Q16 + 16'd1);
        send_item(32'sd0, -32'sd65536, 32'sd65536, 16'hFFFF, 16'hFFFF);
        send_item(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 16'd0, 16'd1);
        send_item(32'h80000000, 32'h80000000, 32'h7FFFFFFF, 16'd0, 16'hFFFF);
        send_item(32'h80000000, 32'h80000000, 32'h7FFFFFFF, 16'd100, 16'd0);
        send_item(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 16'd100, 16'hFFFF);
        send_item(32'sd500, 32'sd500, 32'sd500, 16'd0, 16'd1234);
        send_item(32'sd9, 32'sd700, -32'sd700, 16'd0, 16'd4000);
        send_item(32'sd5000000, 32'sd0, 32'sd65536, 16'd0, 16'd1000);
        send_item(-32'sd5000000, 32'sd0, 32'sd65536, 16'd0, 16'd60000);
        send_item(32'sd5000000, 32'sd0, 32'sd65536, 16'd0, 16'd60000);
        send_item(-32'sd5000000, 32'sd0, 32'sd65536, 16'd0, 16'd1000);
        send_item(32'sd0, 32'sd0, 32'sd65536, 16'd0, 16'd20000);
        send_item(32'sd65536, 32'sd0, 32'sd65536, 16'd0, 16'd40000);
        send_item(32'sd1, 32'sd0, 32'sd1, 16'd0, 16'd0);
        send_item(32'h7FFFFFFF, 32'sd0, 32'sd65536, 16'hFFFF, 16'd0);
        send_item(32'sd12345, 32'sd0, 32'sd65536, 16'hFFFF, 16'hFFFF);
    endtask

    // receiver with random stalls and one long hold-off to back the pipeline up
    initial
    begin
        int stall;
        stall        = 0;
        results_seen = 0;
        result_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (result_valid && result_ready)
            begin
                sb.check_result(new_value, was_mutated);
                results_seen++;
                if (results_seen == 40)
                    stall = 400;
            end
            if (stall > 0)
            begin
                stall--;
                result_ready <= 1'b0;
            end
            else
            begin
                stall        = pick_gap();
                result_ready <= (stall == 0);
                if (stall > 0)
                    stall--;
            end
        end
    end

    initial
    begin
        int i;
        int p;
        int dists[7];
        int probs[7];
        int counts[7];
        dists       = '{5120, 0, 65535, 256, 1000, 65535, 2560};
        probs       = '{65536, 65536, 40000, 0, 32768, 65536, 20000};
        counts      = '{150, 100, 100, 50, 120, 70, 60};
        sb          = new();
        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = REG_DIST_INDEX;
        cfg_data    = '0;
        item_valid  = 1'b0;
        gene_value  = '0;
        lower_bound = '0;
        upper_bound = '0;
        rand_decide = '0;
        rand_shape  = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // reset values of the registers first
        for (i = 0; i < 60; i++)
            send_random();
        item_valid <= 1'b0;
        drain();
        for (p = 0; p < 8; p++)
        begin
            if (p < 7)
            begin
                write_reg(REG_DIST_INDEX, CFG_W'(dists[p]));
                write_reg(REG_MUTATE_PROB, CFG_W'(probs[p]));
            end
            else
            begin
                write_reg(REG_DIST_INDEX, CFG_W'($urandom_range(0, 65535)));
                write_reg(REG_MUTATE_PROB, CFG_W'($urandom_range(0, 65536)));
            end
            @(posedge clk);
            if (p == 0)
                run_directed();
            for (i = 0; i < (p < 7 ? counts[p] : 50); i++)
                send_random();
            item_valid <= 1'b0;
            drain();
        end
        if (sb.pending_q.size() != 0)
        begin
            $error("%0d expected results never arrived", sb.pending_q.size());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/pmut_pkg.sv
hw/rtl/pmut_div.sv
hw/rtl/pmut_log.sv
hw/rtl/pmut_exp.sv
hw/rtl/polynomial_mutation_element.sv
bench/polynomial_mutation_element_tb.sv
